// File: hw/rtl/sm83_pkg.sv
package sm83_pkg;

    localparam int MEM_DEPTH = 65536;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    // command codes
    localparam logic [1:0] CMD_EXEC  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // flag bit positions
    localparam int FZ = 3;
    localparam int FN = 2;
    localparam int FH = 1;
    localparam int FC = 0;

    // command entry passed from front to back
    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] address;
        logic [7:0]  write_data;
    } cmd_t;

    // result transaction
    typedef struct packed {
        logic [15:0] program_counter;
        logic [7:0]  opcode;
        logic [7:0]  accumulator;
        logic [3:0]  flag_bits;
        logic [15:0] pair_bc;
        logic [15:0] pair_de;
        logic [15:0] pair_hl;
        logic [15:0] stack_pointer;
        logic [7:0]  read_data;
        logic        illegal_opcode;
    } result_t;

endpackage

// File: hw/rtl/sm83_cmd_fifo.sv
// Two-entry command queue between front and back
module sm83_cmd_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sm83_pkg::cmd_t   push_data,
    output logic             full,
    input  logic             pop,
    output sm83_pkg::cmd_t   pop_data,
    output logic             empty
);

    sm83_pkg::cmd_t mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push && !full)
                wptr_reg <= ~wptr_reg;
            if (pop && !empty)
                rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push && !full} - {1'b0, pop && !empty};
        end
    end

endmodule

// File: hw/rtl/sm83_core.sv
// Back end: sequencer over a single-port byte memory with registered read.
// Each state issues at most one memory access.
module sm83_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  sm83_pkg::cmd_t    cmd,
    output logic              cmd_pop,
    output logic              res_valid,
    output sm83_pkg::result_t res,
    input  logic              res_pop
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_OP, ST_DEC, ST_IMM1, ST_IMM2, ST_OPND, ST_WR2, ST_DONE
    } state_t;

    logic [7:0] mem [sm83_pkg::MEM_DEPTH];
    logic [7:0] rdata_reg;

    state_t      state_reg;
    logic [15:0] pc_reg, sp_reg;
    logic [7:0]  a_reg, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg;
    logic [3:0]  f_reg;
    logic [7:0]  op_reg, imm_reg, rd_out_reg;
    logic        ill_reg, full_reg;
    logic [1:0]  cmdk_reg;
    logic [15:0] addr_reg;

    // memory port request
    logic        mem_en, mem_we;
    logic [15:0] mem_a;
    logic [7:0]  mem_wd;

    always_ff @(posedge clk)
    begin
        if (mem_en)
        begin
            if (mem_we)
                mem[mem_a[sm83_pkg::MEM_AW-1:0]] <= mem_wd;
            else
                rdata_reg <= mem[mem_a[sm83_pkg::MEM_AW-1:0]];
        end
    end

    // opcode fields
    logic [2:0] lo, mid;
    logic [1:0] p;
    assign lo  = op_reg[2:0];
    assign mid = op_reg[5:3];
    assign p   = op_reg[5:4];

    function automatic logic [7:0] sel_r(input logic [2:0] code, input logic [7:0] memv,
        input logic [7:0] a, input logic [7:0] b, input logic [7:0] c, input logic [7:0] d,
        input logic [7:0] e, input logic [7:0] h, input logic [7:0] l);
        logic [7:0] v;
        unique case (code)
            3'd0: v = b;
            3'd1: v = c;
            3'd2: v = d;
            3'd3: v = e;
            3'd4: v = h;
            3'd5: v = l;
            3'd6: v = memv;
            default: v = a;
        endcase
        return v;
    endfunction

    logic [15:0] hl, rr;
    assign hl = {h_reg, l_reg};
    always_comb
    begin
        unique case (p)
            2'd0: rr = {b_reg, c_reg};
            2'd1: rr = {d_reg, e_reg};
            2'd2: rr = hl;
            default: rr = sp_reg;
        endcase
    end

    // classification of the opcode
    logic is_alu, is_ld, is_illegal, src_mem, dst_mem, needs_imm1, needs_imm2, needs_opnd;
    always_comb
    begin
        is_alu     = (op_reg >= 8'h80) && (op_reg < 8'hB0);
        is_ld      = (op_reg >= 8'h40) && (op_reg < 8'h80);
        is_illegal = (op_reg >= 8'hB0) ||
                     ((op_reg < 8'h40) && (op_reg[2:0] == 3'd7));
        src_mem    = (is_alu || (is_ld && op_reg != 8'h76)) && lo == 3'd6;
        dst_mem    = 1'b0;
        needs_imm1 = 1'b0;
        needs_imm2 = 1'b0;
        needs_opnd = src_mem;
        if (op_reg < 8'h40 && !is_illegal)
        begin
            unique case (op_reg[3:0])
                4'h0, 4'h8:
                begin
                    needs_imm1 = !(op_reg == 8'h00 || op_reg == 8'h10);
                    needs_imm2 = (op_reg == 8'h08);
                end
                4'h1: begin needs_imm1 = 1'b1; needs_imm2 = 1'b1; end
                4'hA: needs_opnd = 1'b1;
                4'h4, 4'h5, 4'hC, 4'hD: needs_opnd = (mid == 3'd6);
                4'h6, 4'hE: needs_imm1 = 1'b1;
                default: ;
            endcase
        end
        if (is_ld && mid == 3'd6 && op_reg != 8'h76)
            dst_mem = 1'b1;
    end

    // execution datapath for the final step (operand = rdata_reg in ST_OPND)
    logic [7:0] src_v, alu_r;
    logic [3:0] alu_f;
    logic [8:0] sum9;
    logic [4:0] h5;
    always_comb
    begin
        src_v = sel_r(lo, rdata_reg, a_reg, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg);
        sum9  = 9'd0;
        h5    = 5'd0;
        alu_f = 4'd0;
        unique case (mid)
            3'd0, 3'd1:
            begin
                sum9 = {1'b0, a_reg} + {1'b0, src_v} + {8'd0, mid[0] & f_reg[sm83_pkg::FC]};
                h5 = {1'b0, a_reg[3:0]} + {1'b0, src_v[3:0]} +
                     {4'd0, mid[0] & f_reg[sm83_pkg::FC]};
                alu_f = {1'b0, 1'b0, h5[4], sum9[8]};
            end
            3'd2, 3'd3:
            begin
                sum9 = {1'b0, a_reg} - {1'b0, src_v} - {8'd0, mid[0] & f_reg[sm83_pkg::FC]};
                h5 = {1'b0, a_reg[3:0]} - {1'b0, src_v[3:0]} -
                     {4'd0, mid[0] & f_reg[sm83_pkg::FC]};
                alu_f = {1'b0, 1'b1, h5[4], sum9[8]};
            end
            3'd4: begin sum9 = {1'b0, a_reg & src_v}; alu_f = 4'b0010; end
            default: begin sum9 = {1'b0, a_reg ^ src_v}; alu_f = 4'b0000; end
        endcase
        alu_r = sum9[7:0];
        alu_f[sm83_pkg::FZ] = (alu_r == 8'd0);
    end

    // write a register by instruction code
    logic [7:0] w_val;
    logic [2:0] w_code;
    logic       w_en;

    logic [16:0] add16;
    logic [12:0] add12;
    assign add16 = {1'b0, hl} + {1'b0, rr};
    assign add12 = {1'b0, hl[11:0]} + {1'b0, rr[11:0]};

    // INC/DEC operand, register or (HL) byte selected by the middle field
    logic [7:0] idv, idr;
    assign idv = sel_r(mid, rdata_reg, a_reg, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg);
    assign idr = op_reg[0] ? idv - 8'd1 : idv + 8'd1;

    logic [15:0] jr_pc;
    assign jr_pc = pc_reg + {{8{rdata_reg[7]}}, rdata_reg};
    logic jr_take, jr_fl;
    assign jr_fl   = op_reg[4] ? f_reg[sm83_pkg::FC] : f_reg[sm83_pkg::FZ];
    assign jr_take = (op_reg == 8'h18) || (op_reg[3] ? jr_fl : !jr_fl);

    // address of the (BC),(DE),(HL+),(HL-) operand
    logic [15:0] ind_a;
    assign ind_a = (p < 2'd2) ? rr : hl;

    // next command may start in the cycle the waiting result is taken
    assign cmd_pop   = (state_reg == ST_IDLE) && cmd_valid && (!full_reg || res_pop);
    assign res_valid = full_reg;

    // memory request decode
    always_comb
    begin
        mem_en = 1'b0;
        mem_we = 1'b0;
        mem_a  = pc_reg;
        mem_wd = a_reg;
        unique case (state_reg)
            ST_IDLE:
                if (cmd_pop)
                begin
                    mem_en = (cmd.command != sm83_pkg::CMD_NONE);
                    mem_we = (cmd.command == sm83_pkg::CMD_WRITE);
                    mem_a  = (cmd.command == sm83_pkg::CMD_EXEC) ? pc_reg : cmd.address;
                    mem_wd = cmd.write_data;
                end
            ST_DEC:
            begin
                if (needs_imm1)
                    mem_en = 1'b1;
                else if (needs_opnd)
                begin
                    mem_en = 1'b1;
                    mem_a  = (op_reg < 8'h40 && op_reg[3:0] == 4'hA) ? ind_a : hl;
                end
                else if (op_reg < 8'h40 && op_reg[3:0] == 4'h2)
                begin
                    mem_en = 1'b1;
                    mem_we = 1'b1;
                    mem_a  = ind_a;
                end
                else if (dst_mem)
                begin
                    mem_en = 1'b1;
                    mem_we = 1'b1;
                    mem_a  = hl;
                    mem_wd = src_v;
                end
            end
            ST_IMM1:
                if (needs_imm2)
                    mem_en = 1'b1;
                else if (op_reg[3:0] == 4'h6 && mid == 3'd6)
                begin
                    mem_en = 1'b1;
                    mem_we = 1'b1;
                    mem_a  = hl;
                    mem_wd = rdata_reg;
                end
            ST_IMM2:
                if (op_reg == 8'h08)
                begin
                    mem_en = 1'b1;
                    mem_we = 1'b1;
                    mem_a  = {rdata_reg, imm_reg};
                    mem_wd = sp_reg[7:0];
                end
            ST_WR2:
            begin
                mem_en = 1'b1;
                mem_we = 1'b1;
                mem_a  = addr_reg;
                mem_wd = sp_reg[15:8];
            end
            ST_OPND:
                if ((op_reg[3:0] == 4'h4 || op_reg[3:0] == 4'h5 || op_reg[3:0] == 4'hC ||
                     op_reg[3:0] == 4'hD) && op_reg < 8'h40)
                begin
                    mem_en = 1'b1;
                    mem_we = 1'b1;
                    mem_a  = hl;
                    mem_wd = idr;
                end
            default: ;
        endcase
    end

    // register write from an 8-bit result
    always_comb
    begin
        w_en   = 1'b0;
        w_code = mid;
        w_val  = idr;
        unique case (state_reg)
            ST_DEC:
                if (!needs_imm1 && !needs_opnd && !dst_mem)
                begin
                    if (is_alu) begin w_en = 1'b1; w_code = 3'd7; w_val = alu_r; end
                    else if (is_ld && op_reg != 8'h76)
                        begin w_en = 1'b1; w_val = src_v; end
                    else if (op_reg < 8'h40 && (op_reg[2:1] == 2'b10) && mid != 3'd6)
                        w_en = 1'b1;
                end
            ST_IMM1:
                if (!needs_imm2 && (op_reg[3:0] == 4'h6 || op_reg[3:0] == 4'hE) && mid != 3'd6)
                    begin w_en = 1'b1; w_val = rdata_reg; end
            ST_OPND:
                if (is_alu) begin w_en = 1'b1; w_code = 3'd7; w_val = alu_r; end
                else if (is_ld) begin w_en = 1'b1; w_val = rdata_reg; end
                else if (op_reg[3:0] == 4'hA)
                    begin w_en = 1'b1; w_code = 3'd7; w_val = rdata_reg; end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg <= 16'd0; sp_reg <= 16'd0;
            a_reg <= 8'd0; b_reg <= 8'd0; c_reg <= 8'd0; d_reg <= 8'd0;
            e_reg <= 8'd0; h_reg <= 8'd0; l_reg <= 8'd0; f_reg <= 4'd0;
            full_reg <= 1'b0;
            op_reg <= 8'd0; imm_reg <= 8'd0; rd_out_reg <= 8'd0; ill_reg <= 1'b0;
            cmdk_reg <= 2'd0; addr_reg <= 16'd0;
        end
        else
        begin
            if (res_pop && full_reg)
                full_reg <= 1'b0;
            if (w_en)
            begin
                unique case (w_code)
                    3'd0: b_reg <= w_val;
                    3'd1: c_reg <= w_val;
                    3'd2: d_reg <= w_val;
                    3'd3: e_reg <= w_val;
                    3'd4: h_reg <= w_val;
                    3'd5: l_reg <= w_val;
                    3'd7: a_reg <= w_val;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                    if (cmd_pop)
                    begin
                        cmdk_reg <= cmd.command;
                        ill_reg  <= 1'b0;
                        op_reg   <= 8'd0;
                        rd_out_reg <= 8'd0;
                        if (cmd.command == sm83_pkg::CMD_EXEC)
                        begin
                            pc_reg    <= pc_reg + 16'd1;
                            state_reg <= ST_OP;
                        end
                        else if (cmd.command == sm83_pkg::CMD_READ)
                            state_reg <= ST_OP;
                        else
                            state_reg <= ST_DONE;
                    end
                ST_OP:
                    if (cmdk_reg == sm83_pkg::CMD_READ)
                    begin
                        rd_out_reg <= rdata_reg;
                        state_reg  <= ST_DONE;
                    end
                    else
                    begin
                        op_reg    <= rdata_reg;
                        state_reg <= ST_DEC;
                    end
                ST_DEC:
                begin
                    state_reg <= ST_DONE;
                    if (is_illegal)
                        ill_reg <= 1'b1;
                    else if (needs_imm1)
                    begin
                        pc_reg    <= pc_reg + 16'd1;
                        state_reg <= ST_IMM1;
                    end
                    else if (needs_opnd)
                        state_reg <= ST_OPND;
                    else if (is_alu)
                        f_reg <= alu_f;
                    else if (op_reg < 8'h40)
                    begin
                        unique case (op_reg[3:0])
                            4'h2:
                                if (p == 2'd2) {h_reg, l_reg} <= hl + 16'd1;
                                else if (p == 2'd3) {h_reg, l_reg} <= hl - 16'd1;
                            4'h3, 4'hB:
                            begin
                                unique case (p)
                                    2'd0: {b_reg, c_reg} <= op_reg[3] ? rr - 16'd1 : rr + 16'd1;
                                    2'd1: {d_reg, e_reg} <= op_reg[3] ? rr - 16'd1 : rr + 16'd1;
                                    2'd2: {h_reg, l_reg} <= op_reg[3] ? rr - 16'd1 : rr + 16'd1;
                                    default: sp_reg <= op_reg[3] ? rr - 16'd1 : rr + 16'd1;
                                endcase
                            end
                            4'h9:
                            begin
                                {h_reg, l_reg} <= add16[15:0];
                                f_reg <= {f_reg[sm83_pkg::FZ], 1'b0, add12[12], add16[16]};
                            end
                            4'h4, 4'h5, 4'hC, 4'hD:
                                f_reg <= {idr == 8'd0, op_reg[0],
                                          op_reg[0] ? (idv[3:0] == 4'h0) : (idv[3:0] == 4'hF),
                                          f_reg[sm83_pkg::FC]};
                            default: ;
                        endcase
                    end
                end
                ST_IMM1:
                begin
                    imm_reg   <= rdata_reg;
                    state_reg <= ST_DONE;
                    if (needs_imm2)
                    begin
                        pc_reg    <= pc_reg + 16'd1;
                        state_reg <= ST_IMM2;
                    end
                    else if (op_reg[2:0] == 3'd0 && jr_take)
                        pc_reg <= jr_pc;
                end
                ST_IMM2:
                begin
                    state_reg <= ST_DONE;
                    if (op_reg == 8'h08)
                    begin
                        addr_reg  <= {rdata_reg, imm_reg} + 16'd1;
                        state_reg <= ST_WR2;
                    end
                    else
                    begin
                        unique case (p)
                            2'd0: {b_reg, c_reg} <= {rdata_reg, imm_reg};
                            2'd1: {d_reg, e_reg} <= {rdata_reg, imm_reg};
                            2'd2: {h_reg, l_reg} <= {rdata_reg, imm_reg};
                            default: sp_reg <= {rdata_reg, imm_reg};
                        endcase
                    end
                end
                ST_WR2: state_reg <= ST_DONE;
                ST_OPND:
                begin
                    state_reg <= ST_DONE;
                    if (is_alu)
                        f_reg <= alu_f;
                    else if (op_reg < 8'h40 && op_reg[3:0] == 4'hA)
                    begin
                        if (p == 2'd2) {h_reg, l_reg} <= hl + 16'd1;
                        else if (p == 2'd3) {h_reg, l_reg} <= hl - 16'd1;
                    end
                    else if (op_reg < 8'h40)
                        f_reg <= {idr == 8'd0, op_reg[0],
                                  op_reg[0] ? (idv[3:0] == 4'h0) : (idv[3:0] == 4'hF),
                                  f_reg[sm83_pkg::FC]};
                end
                ST_DONE:
                begin
                    full_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign res.program_counter = pc_reg;
    assign res.opcode          = op_reg;
    assign res.accumulator     = a_reg;
    assign res.flag_bits       = f_reg;
    assign res.pair_bc         = {b_reg, c_reg};
    assign res.pair_de         = {d_reg, e_reg};
    assign res.pair_hl         = hl;
    assign res.stack_pointer   = sp_reg;
    assign res.read_data       = rd_out_reg;
    assign res.illegal_opcode  = ill_reg;

endmodule

// File: hw/rtl/sm83_subset_instruction_executor.sv
// SM83-subset executor with a private 64 KiB byte memory.
// Input channel: push/full. A transaction carries command (0 execute,
// 1 write byte, 2 read byte), address and write_data. Commands enter a
// two-entry queue, so push can be taken while the core is busy.
// Result channel: empty/pop. One result per command shows PC, opcode,
// A, flags, BC, DE, HL, SP, read_data and illegal_opcode.
// An accepted push enters the queue. A write then goes to ST_DONE, a read
// passes ST_OP, an execute ST_OP and ST_DEC plus one more state per immediate
// byte or memory operand read; SP store to an absolute address adds ST_WR2.
// Throughput is set by the single memory port and the sequencer: one command
// at a time, back to back as long as each result is popped when it appears;
// the next command starts on that pop.
// Reset clears the CPU state and empties the queue; memory is undefined until
// written. When the receiver stalls, the result holds and the core waits
// with its next command; the queue then fills and raises full.
module sm83_subset_instruction_executor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  command,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] program_counter,
    output logic [7:0]  opcode,
    output logic [7:0]  accumulator,
    output logic [3:0]  flag_bits,
    output logic [15:0] pair_bc,
    output logic [15:0] pair_de,
    output logic [15:0] pair_hl,
    output logic [15:0] stack_pointer,
    output logic [7:0]  read_data,
    output logic        illegal_opcode
);

    sm83_pkg::cmd_t    in_cmd, q_cmd;
    sm83_pkg::result_t res;
    logic q_empty, q_pop, res_valid;

    assign in_cmd.command    = command;
    assign in_cmd.address    = address;
    assign in_cmd.write_data = write_data;

    sm83_cmd_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (in_cmd),
        .full      (full),
        .pop       (q_pop),
        .pop_data  (q_cmd),
        .empty     (q_empty)
    );

    sm83_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_empty),
        .cmd       (q_cmd),
        .cmd_pop   (q_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_pop   (pop)
    );

    assign empty           = !res_valid;
    assign program_counter = res.program_counter;
    assign opcode          = res.opcode;
    assign accumulator     = res.accumulator;
    assign flag_bits       = res.flag_bits;
    assign pair_bc         = res.pair_bc;
    assign pair_de         = res.pair_de;
    assign pair_hl         = res.pair_hl;
    assign stack_pointer   = res.stack_pointer;
    assign read_data       = res.read_data;
    assign illegal_opcode  = res.illegal_opcode;

endmodule

// File: tb/tb_sm83_subset_instruction_executor.sv
`timescale 1ns / 1ps

module tb_sm83_subset_instruction_executor;

    import sm83_pkg::*;

    // command code that the block ignores
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int ITEMS_TARGET   = 1150;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        empty;
    logic        pop;
    logic [15:0] program_counter;
    logic [7:0]  opcode;
    logic [7:0]  accumulator;
    logic [3:0]  flag_bits;
    logic [15:0] pair_bc;
    logic [15:0] pair_de;
    logic [15:0] pair_hl;
    logic [15:0] stack_pointer;
    logic [7:0]  read_data;
    logic        illegal_opcode;

    sm83_subset_instruction_executor i_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .command         (command),
        .address         (address),
        .write_data      (write_data),
        .empty           (empty),
        .pop             (pop),
        .program_counter (program_counter),
        .opcode          (opcode),
        .accumulator     (accumulator),
        .flag_bits       (flag_bits),
        .pair_bc         (pair_bc),
        .pair_de         (pair_de),
        .pair_hl         (pair_hl),
        .stack_pointer   (stack_pointer),
        .read_data       (read_data),
        .illegal_opcode  (illegal_opcode)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // CPU shadow: memory, written marks and registers (A B C D E H L)
    // ------------------------------------------------------------------
    logic [7:0]  shadow_mem [0:65535];
    bit          mem_known  [0:65535];
    logic [15:0] known_addrs[$];
    logic [15:0] cpu_pc;
    logic [15:0] cpu_sp;
    logic [7:0]  cpu_regs [0:6];
    logic [3:0]  cpu_flags;

    cmd_t    pending_cmds[$];
    result_t expected_results[$];
    int      total_items;
    int      sent_count;
    int      got_count;
    int      fail_count;

    function automatic logic [15:0] get_hl();
        return {cpu_regs[5], cpu_regs[6]};
    endfunction

    function automatic void mem_store(input logic [15:0] a, input logic [7:0] v);
        shadow_mem[a] = v;
        if (!mem_known[a])
        begin
            mem_known[a] = 1'b1;
            known_addrs.push_back(a);
        end
    endfunction

    function automatic void fetch_byte(output logic [7:0] v);
        v = shadow_mem[cpu_pc];
        cpu_pc = cpu_pc + 16'd1;
    endfunction

    function automatic void fetch_word(output logic [15:0] v);
        logic [7:0] lo;
        logic [7:0] hi;
        fetch_byte(lo);
        fetch_byte(hi);
        v = {hi, lo};
    endfunction

    // pair code 0 BC, 1 DE, 2 HL, 3 SP
    function automatic logic [15:0] get_pair(input logic [1:0] p);
        if (p == 2'd3)
            return cpu_sp;
        return {cpu_regs[1 + 2 * p], cpu_regs[2 + 2 * p]};
    endfunction

    function automatic void set_pair(input logic [1:0] p, input logic [15:0] v);
        if (p == 2'd3)
            cpu_sp = v;
        else
        begin
            cpu_regs[1 + 2 * p] = v[15:8];
            cpu_regs[2 + 2 * p] = v[7:0];
        end
    endfunction

    // register code B C D E H L (HL) A
    function automatic logic [7:0] get_reg8(input logic [2:0] code);
        if (code == 3'd6)
            return shadow_mem[get_hl()];
        if (code == 3'd7)
            return cpu_regs[0];
        return cpu_regs[code + 1];
    endfunction

    function automatic void set_reg8(input logic [2:0] code, input logic [7:0] v);
        if (code == 3'd6)
            mem_store(get_hl(), v);
        else if (code == 3'd7)
            cpu_regs[0] = v;
        else
            cpu_regs[code + 1] = v;
    endfunction

    function automatic void alu_op(input logic [2:0] op, input logic [7:0] b);
        int a;
        int c;
        int r;
        logic [3:0] f;
        a = cpu_regs[0];
        c = (op == 3'd1 || op == 3'd3) ? int'(cpu_flags[FC]) : 0;
        f = '0;
        case (op)
            3'd0, 3'd1:
            begin
                r = a + b + c;
                f[FH] = ((a & 15) + (b & 15) + c) > 15;
                f[FC] = r > 255;
            end
            3'd2, 3'd3:
            begin
                r = a - b - c;
                f[FN] = 1'b1;
                f[FH] = (a & 15) < ((b & 15) + c);
                f[FC] = a < (b + c);
            end
            3'd4:
            begin
                r = a & b;
                f[FH] = 1'b1;
            end
            default:
                r = a ^ b;
        endcase
        r = r & 255;
        f[FZ] = (r == 0);
        cpu_regs[0] = r[7:0];
        cpu_flags = f;
    endfunction

    // one instruction; returns 0 for an unhandled opcode
    function automatic bit run_opcode(input logic [7:0] op);
        logic [2:0]  lo;
        logic [2:0]  mid;
        logic [1:0]  p;
        logic [7:0]  d;
        logic [7:0]  v;
        logic [15:0] w;
        logic [16:0] s;
        bit          fl;
        lo  = op[2:0];
        mid = op[5:3];
        p   = op[5:4];
        if (op >= 8'hB0)
            return 0;
        if (op >= 8'h80)
        begin
            alu_op(mid, get_reg8(lo));
            return 1;
        end
        if (op >= 8'h40)
        begin
            if (op != 8'h76)
                set_reg8(mid, get_reg8(lo));
            return 1;
        end
        case (op[3:0])
            4'h0, 4'h8:
            begin
                if (op == 8'h00 || op == 8'h10)
                    return 1;
                if (op == 8'h08)
                begin
                    fetch_word(w);
                    mem_store(w, cpu_sp[7:0]);
                    mem_store(w + 16'd1, cpu_sp[15:8]);
                end
                else
                begin
                    // relative jump, conditional on Z or C except 0x18
                    fetch_byte(d);
                    fl = op[4] ? cpu_flags[FC] : cpu_flags[FZ];
                    if (op == 8'h18 || (op[3] ? fl : !fl))
                        cpu_pc = cpu_pc + {{8{d[7]}}, d};
                end
            end
            4'h1:
            begin
                fetch_word(w);
                set_pair(p, w);
            end
            4'h2, 4'hA:
            begin
                w = (p < 2) ? get_pair(p) : get_hl();
                if (op[3])
                    cpu_regs[0] = shadow_mem[w];
                else
                    mem_store(w, cpu_regs[0]);
                if (p == 2'd2)
                    set_pair(2'd2, w + 16'd1);
                if (p == 2'd3)
                    set_pair(2'd2, w - 16'd1);
            end
            4'h3: set_pair(p, get_pair(p) + 16'd1);
            4'hB: set_pair(p, get_pair(p) - 16'd1);
            4'h9:
            begin
                w = get_pair(p);
                s = {1'b0, get_hl()} + {1'b0, w};
                cpu_flags[FN] = 1'b0;
                cpu_flags[FH] = ({1'b0, get_hl() & 16'h0FFF} + {1'b0, w & 16'h0FFF}) > 17'h0FFF;
                cpu_flags[FC] = s[16];
                set_pair(2'd2, s[15:0]);
            end
            4'h4, 4'hC:
            begin
                v = get_reg8(mid);
                cpu_flags[FZ] = (v + 8'd1) == 8'd0;
                cpu_flags[FN] = 1'b0;
                cpu_flags[FH] = v[3:0] == 4'hF;
                set_reg8(mid, v + 8'd1);
            end
            4'h5, 4'hD:
            begin
                v = get_reg8(mid);
                cpu_flags[FZ] = (v - 8'd1) == 8'd0;
                cpu_flags[FN] = 1'b1;
                cpu_flags[FH] = v[3:0] == 4'h0;
                set_reg8(mid, v - 8'd1);
            end
            4'h6, 4'hE:
            begin
                fetch_byte(d);
                set_reg8(mid, d);
            end
            default:
                return 0;
        endcase
        return 1;
    endfunction

    // predict the result of one command, then queue command and result
    task automatic add_command(input logic [1:0] cmd, input logic [15:0] a,
                               input logic [7:0] wd);
        cmd_t    c;
        result_t r;
        r = '0;
        if (cmd == CMD_EXEC)
        begin
            fetch_byte(r.opcode);
            r.illegal_opcode = !run_opcode(r.opcode);
        end
        else if (cmd == CMD_WRITE)
            mem_store(a, wd);
        else if (cmd == CMD_READ)
            r.read_data = shadow_mem[a];
        r.program_counter = cpu_pc;
        r.accumulator     = cpu_regs[0];
        r.flag_bits       = cpu_flags;
        r.pair_bc         = get_pair(2'd0);
        r.pair_de         = get_pair(2'd1);
        r.pair_hl         = get_hl();
        r.stack_pointer   = cpu_sp;
        c.command    = cmd;
        c.address    = a;
        c.write_data = wd;
        pending_cmds.push_back(c);
        expected_results.push_back(r);
    endtask

    // address of the data byte an opcode reads, if any
    function automatic bit operand_read(input logic [7:0] op, output logic [15:0] a);
        a = get_hl();
        if (op >= 8'hB0)
            return 0;
        if (op >= 8'h80)
            return op[2:0] == 3'd6;
        if (op >= 8'h40)
            return op != 8'h76 && op[2:0] == 3'd6;
        if (op == 8'h0A || op == 8'h1A)
        begin
            a = get_pair(op[5:4]);
            return 1;
        end
        return op == 8'h2A || op == 8'h3A || op == 8'h34 || op == 8'h35;
    endfunction

    // lay down an instruction at PC (and its operand), then execute it;
    // bytes already in memory are sometimes reused as they stand
    task automatic add_instruction(input logic [7:0] op, input logic [7:0] b1,
                                   input logic [7:0] b2, input bit force_wr);
        logic [15:0] opnd;
        if (operand_read(op, opnd))
            if (force_wr || !mem_known[opnd] || $urandom_range(1) == 0)
                add_command(CMD_WRITE, opnd, 8'($urandom));
        if (force_wr || !mem_known[cpu_pc] || $urandom_range(3) != 0)
            add_command(CMD_WRITE, cpu_pc, op);
        if (force_wr || !mem_known[cpu_pc + 16'd1] || $urandom_range(1) == 0)
            add_command(CMD_WRITE, cpu_pc + 16'd1, b1);
        if (force_wr || !mem_known[cpu_pc + 16'd2] || $urandom_range(1) == 0)
            add_command(CMD_WRITE, cpu_pc + 16'd2, b2);
        // the operand write may have landed in the code bytes; recheck
        if (operand_read(shadow_mem[cpu_pc], opnd) && !mem_known[opnd])
            add_command(CMD_WRITE, opnd, 8'($urandom));
        add_command(CMD_EXEC, 16'($urandom), 8'($urandom));
    endtask

    // stimulus: directed part, then random sequences
    initial
    begin
        logic [7:0] op;
        int         pick;
        for (int i = 0; i < 65536; i++)
            mem_known[i] = 1'b0;
        cpu_pc    = '0;
        cpu_sp    = '0;
        cpu_flags = '0;
        for (int i = 0; i < 7; i++)
            cpu_regs[i] = '0;

        // memory extremes and the ignored command
        add_command(CMD_WRITE, 16'hFFFF, 8'hFF);
        add_command(CMD_READ, 16'hFFFF, 8'h00);
        add_command(CMD_NONE, 16'hFFFF, 8'hFF);
        // SP load and store, HL add with carries, 8-bit flag edges
        add_instruction(8'h31, 8'hFF, 8'hFF, 1);
        add_instruction(8'h08, 8'h00, 8'h80, 1);
        add_instruction(8'h21, 8'hFF, 8'hFF, 1);
        add_instruction(8'h29, 8'h00, 8'h00, 1);
        add_instruction(8'h3E, 8'hFF, 8'h00, 1);
        add_instruction(8'h3C, 8'h00, 8'h00, 1);
        add_instruction(8'h3D, 8'h00, 8'h00, 1);
        add_instruction(8'hC6, 8'h00, 8'h00, 1);
        add_instruction(8'h07, 8'h00, 8'h00, 1);
        add_instruction(8'h76, 8'h00, 8'h00, 1);
        add_instruction(8'h10, 8'h00, 8'h00, 1);
        add_instruction(8'h18, 8'h80, 8'h00, 1);
        for (int k = 0; k < 6; k++)
            add_instruction(8'h80 + 8'(k * 8) + 8'd7, 8'h00, 8'h00, 1);
        add_instruction(8'h28, 8'h7F, 8'h00, 1);

        // random part: mostly instruction sequences
        while (pending_cmds.size() < ITEMS_TARGET)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                op = (pick < 55) ? 8'($urandom_range(8'hAF)) : 8'($urandom);
                add_instruction(op, 8'($urandom), 8'($urandom), 0);
            end
            else if (pick < 85)
                add_command(CMD_WRITE, 16'($urandom), 8'($urandom));
            else if (pick < 95)
                add_command(CMD_READ,
                            known_addrs[$urandom_range(known_addrs.size() - 1)],
                            8'($urandom));
            else
                add_command(CMD_NONE, 16'($urandom), 8'($urandom));
        end
        total_items = pending_cmds.size();

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        wait (sent_count == total_items && expected_results.size() == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // idle chance for the current phase (receiver idle first, sender second)
    function automatic int idle_pct(input bit receiver);
        if (sent_count < total_items / 3)
            return receiver ? 79 : 17;
        if (sent_count < 2 * total_items / 3)
            return receiver ? 17 : 79;
        return 0;
    endfunction

    // driver
    initial
    begin
        push       = 1'b0;
        command    = CMD_NONE;
        address    = '0;
        write_data = '0;
        sent_count = 0;
        pop        = 1'b0;
        got_count  = 0;
        fail_count = 0;
    end

    always @(posedge clk)
    begin
        cmd_t c;
        bit   busy;
        if (rst_n)
        begin
            busy = push;
            if (push && !full)
            begin
                sent_count <= sent_count + 1;
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct(0))
                begin
                    c = pending_cmds.pop_front();
                    command    <= c.command;
                    address    <= c.address;
                    write_data <= c.write_data;
                    push       <= 1'b1;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // monitor: compare each transaction with the oldest prediction
    int hold_left = 0;

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                got_count <= got_count + 1;
                if (expected_results.size() == 0)
                begin
                    $error("result with no prediction waiting");
                    fail_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (program_counter !== e.program_counter)
                    begin
                        $error("program_counter exp %h got %h", e.program_counter,
                               program_counter);
                        fail_count++;
                    end
                    if (opcode !== e.opcode)
                    begin
                        $error("opcode exp %h got %h", e.opcode, opcode);
                        fail_count++;
                    end
                    if (accumulator !== e.accumulator)
                    begin
                        $error("accumulator exp %h got %h", e.accumulator, accumulator);
                        fail_count++;
                    end
                    if (flag_bits !== e.flag_bits)
                    begin
                        $error("flag_bits exp %h got %h", e.flag_bits, flag_bits);
                        fail_count++;
                    end
                    if (pair_bc !== e.pair_bc)
                    begin
                        $error("pair_bc exp %h got %h", e.pair_bc, pair_bc);
                        fail_count++;
                    end
                    if (pair_de !== e.pair_de)
                    begin
                        $error("pair_de exp %h got %h", e.pair_de, pair_de);
                        fail_count++;
                    end
                    if (pair_hl !== e.pair_hl)
                    begin
                        $error("pair_hl exp %h got %h", e.pair_hl, pair_hl);
                        fail_count++;
                    end
                    if (stack_pointer !== e.stack_pointer)
                    begin
                        $error("stack_pointer exp %h got %h", e.stack_pointer,
                               stack_pointer);
                        fail_count++;
                    end
                    if (read_data !== e.read_data)
                    begin
                        $error("read_data exp %h got %h", e.read_data, read_data);
                        fail_count++;
                    end
                    if (illegal_opcode !== e.illegal_opcode)
                    begin
                        $error("illegal_opcode exp %h got %h", e.illegal_opcode,
                               illegal_opcode);
                        fail_count++;
                    end
                end
            end
            // long hold-off once, early in the no-idle phase, to fill the block
            if (got_count == 2 * total_items / 3 + 10 && hold_left == 0 && pop)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= idle_pct(1));
        end
    end

    // watchdog: cycles with no transaction on either side
    int stall_cycles = 0;

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule
